// ===== rtl/dash_comment_stripper_core_assert.svh =====
// Assertion macros shared by the checker of the comment stripper core.
`ifndef DASH_COMMENT_STRIPPER_CORE_ASSERT_SVH
`define DASH_COMMENT_STRIPPER_CORE_ASSERT_SVH

// same-cycle implication, quiet while reset is high
`define DCS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet while reset is high
`define DCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define DCS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/dcs_pkg.sv =====
// Package: types, constants and the normal-text filter function of the stripper.
`timescale 1ns / 1ps

package dcs_pkg;

   localparam logic [7:0] DASH_CHAR    = 8'h2D;
   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
   localparam int         REPORT_WIDTH = 16;
   localparam int         QUEUE_DEPTH  = 4;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_LINE   = 2'd1,
      MODE_BLOCK  = 2'd2
   } dcs_mode_type;

   // one accepted byte's worth of results (one or two beats)
   typedef struct packed {
      logic                    two;
      logic [7:0]              byte0;
      logic [7:0]              byte1;
      logic                    has_byte;
      logic                    last;
      logic [REPORT_WIDTH-1:0] line_total;
      logic [REPORT_WIDTH-1:0] block_total;
   } dcs_entry_type;

   // outcome of one byte filtered as normal text
   typedef struct packed {
      logic [1:0] held;
      logic [1:0] n;
      logic [7:0] b0;
      logic [7:0] b1;
      logic       bump;
      logic       to_block;
      logic       to_line;
   } dcs_norm_type;

   function automatic dcs_norm_type dcs_normal(input logic [1:0] held,
                                               input logic [7:0] c,
                                               input logic       fin);
      dcs_norm_type r;
      r = '0;
      unique case (held)
         2'd0: begin
            if (c == DASH_CHAR && !fin) begin
               r.held = 2'd1;
            end else begin
               r.n  = 2'd1;
               r.b0 = c;
            end
         end
         2'd1: begin
            if (c == DASH_CHAR) begin
               if (fin) begin
                  r.bump = 1'b1;
               end else begin
                  r.held = 2'd2;
               end
            end else begin
               r.n  = 2'd2;
               r.b0 = DASH_CHAR;
               r.b1 = c;
            end
         end
         default: begin
            // two dashes held: third dash opens a block (unless it ends the text), anything else a line comment
            if (c == DASH_CHAR) begin
               r.to_block = !fin;
            end else begin
               r.bump = 1'b1;
               if (c == NEWLINE_CHAR) begin
                  r.n  = 2'd1;
                  r.b0 = NEWLINE_CHAR;
               end else begin
                  r.to_line = !fin;
               end
            end
         end
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/dcs_req_if.sv =====
// Input channel: one source text byte per beat.
`timescale 1ns / 1ps

interface dcs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_text;

   modport source (output valid, output in_byte, output end_of_text, input ready);
   modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

// ===== rtl/dcs_rsp_if.sv =====
// Result channel: at most one cleaned byte and the comment totals per beat.
`timescale 1ns / 1ps

interface dcs_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        has_byte;
   logic        last_result;
   logic [15:0] line_comment_total;
   logic [15:0] block_comment_total;

   modport source (output valid, output out_byte, output has_byte, output last_result,
                   output line_comment_total, output block_comment_total, input ready);
   modport sink   (input valid, input out_byte, input has_byte, input last_result,
                   input line_comment_total, input block_comment_total, output ready);
endinterface

// ===== rtl/dash_comment_stripper_core.sv =====
// Top level of the dash comment stripper: front end, group queue and back end.
`timescale 1ns / 1ps

// Dash comment stripper. Streams source text in, one byte per req beat, and
// streams the text back with comments removed, one byte per rsp beat. "---"
// opens a block comment closed by the next "---"; "--" starts a line comment
// that runs to the newline, and the newline is kept. Mark the final byte of
// a text with end_of_text: that byte always yields at least one rsp beat, the
// last one flagged last_result (has_byte low if no byte was left to keep),
// and all scanner state and both counters restart for the next text. Every
// rsp beat carries the running line and block comment totals (saturating at
// COUNT_WIDTH bits, shown as the low 16 bits). Rate: one req beat per cycle
// while the four-group queue has room; a byte resolves in the same cycle it
// is taken. The back end sends one rsp beat per cycle while rsp_ch.ready is
// high, so a byte that yields two beats (a held dash released with the byte
// after it) costs an extra beat; sustained throughput is set by that single
// output register. A byte's first beat passes the group queue and then the
// output register before it is offered. No clearing pass after reset.

module dash_comment_stripper_core import dcs_pkg::*; #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   dcs_req_if.sink   req_ch,
   dcs_rsp_if.source rsp_ch
);

   logic          push_valid, push_ready;
   dcs_entry_type push_entry;
   logic          head_valid, head_pop;
   dcs_entry_type head_entry;

   // front: scanner state machine, resolves each byte combinationally
   dcs_front #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   // decouples the byte-rate front from the beat-rate back
   dcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .head_entry (head_entry)
   );

   // back: one or two rsp beats per group
   dcs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .head_pop   (head_pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

// ===== rtl/dcs_front.sv =====
// Front end: scanner state, comment classification and result grouping per byte.
`timescale 1ns / 1ps

module dcs_front import dcs_pkg::*; #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic          clock,
   input  logic          reset,
   dcs_req_if.sink       req_ch,
   input  logic          push_ready,
   output logic          push_valid,
   output dcs_entry_type push_entry
);

   dcs_mode_type           mode_ff, mode_in;
   logic [1:0]             held_ff, held_in;
   logic [1:0]             run_ff, run_in;
   logic [1:0]             tcnt_ff, tcnt_in;
   logic [7:0]             tail1_ff, tail1_in;
   logic [COUNT_WIDTH-1:0] line_ff, line_in;
   logic [COUNT_WIDTH-1:0] block_ff, block_in;

   logic         accept;
   logic         fin;
   logic [7:0]   c;
   logic [1:0]   n;
   logic [7:0]   b0, b1;
   logic         line_bump, block_bump;
   dcs_norm_type first, second, plain;

   assign c            = req_ch.in_byte;
   assign fin          = req_ch.end_of_text;
   assign req_ch.ready = push_ready;
   assign accept       = req_ch.valid && push_ready;

   always_comb begin
      mode_in    = mode_ff;
      held_in    = held_ff;
      run_in     = run_ff;
      tcnt_in    = tcnt_ff;
      tail1_in   = tail1_ff;
      n          = 2'd0;
      b0         = 8'd0;
      b1         = 8'd0;
      line_bump  = 1'b0;
      block_bump = 1'b0;
      first      = '0;
      second     = '0;
      plain      = '0;
      unique case (mode_ff)
         MODE_BLOCK: begin
            if (c == DASH_CHAR && run_ff == 2'd2) begin
               block_bump = 1'b1;
               mode_in    = MODE_NORMAL;
               run_in     = 2'd0;
               tcnt_in    = 2'd0;
            end else begin
               run_in   = (c == DASH_CHAR) ? run_ff + 2'd1 : 2'd0;
               tail1_in = c;
               tcnt_in  = (tcnt_ff == 2'd2) ? 2'd2 : tcnt_ff + 2'd1;
               if (fin) begin
                  // unterminated block: replay the last body bytes as normal text
                  if (tcnt_in == 2'd2) begin
                     first = dcs_normal(2'd0, tail1_ff, 1'b0);
                  end
                  second    = dcs_normal(first.held, c, 1'b1);
                  line_bump = second.bump;
                  mode_in   = MODE_NORMAL;
                  if (first.n == 2'd1) begin
                     n  = 2'd1 + second.n;
                     b0 = first.b0;
                     b1 = second.b0;
                  end else begin
                     n  = second.n;
                     b0 = second.b0;
                     b1 = second.b1;
                  end
               end
            end
         end
         MODE_LINE: begin
            if (c == NEWLINE_CHAR) begin
               n       = 2'd1;
               b0      = NEWLINE_CHAR;
               mode_in = MODE_NORMAL;
            end
         end
         default: begin
            plain     = dcs_normal(held_ff, c, fin);
            held_in   = plain.held;
            n         = plain.n;
            b0        = plain.b0;
            b1        = plain.b1;
            line_bump = plain.bump;
            if (plain.to_block) begin
               mode_in = MODE_BLOCK;
               run_in  = 2'd0;
               tcnt_in = 2'd0;
            end else if (plain.to_line) begin
               mode_in = MODE_LINE;
            end
         end
      endcase
      line_in  = (line_bump && line_ff != '1) ? line_ff + 1'b1 : line_ff;
      block_in = (block_bump && block_ff != '1) ? block_ff + 1'b1 : block_ff;
   end

   always_comb begin
      push_valid             = req_ch.valid && (n != 2'd0 || fin);
      push_entry.two         = (n == 2'd2);
      push_entry.byte0       = b0;
      push_entry.byte1       = b1;
      push_entry.has_byte    = (n != 2'd0);
      push_entry.last        = fin;
      push_entry.line_total  = REPORT_WIDTH'(line_in);
      push_entry.block_total = REPORT_WIDTH'(block_in);
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && fin)) begin
         mode_ff  <= MODE_NORMAL;
         held_ff  <= 2'd0;
         run_ff   <= 2'd0;
         tcnt_ff  <= 2'd0;
         line_ff  <= '0;
         block_ff <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         held_ff  <= held_in;
         run_ff   <= run_in;
         tcnt_ff  <= tcnt_in;
         line_ff  <= line_in;
         block_ff <= block_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tail1_ff <= tail1_in;
      end
   end

endmodule

// ===== rtl/dcs_queue.sv =====
// Short FIFO of result groups between the front and back ends.
`timescale 1ns / 1ps

module dcs_queue import dcs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  dcs_entry_type push_entry,
   output logic          head_valid,
   input  logic          head_pop,
   output dcs_entry_type head_entry
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [PTR_W:0]   FULL_CNT  = (PTR_W + 1)'(QUEUE_DEPTH);

   dcs_entry_type    slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = head_pop && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/dcs_back.sv =====
// Back end: splits result groups into beats and holds the output register.
`timescale 1ns / 1ps

module dcs_back import dcs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  dcs_entry_type head_entry,
   output logic          head_pop,
   dcs_rsp_if.source     rsp_ch
);

   logic                    valid_ff;
   logic                    sub_ff;
   logic [7:0]              byte_ff, byte_in;
   logic                    has_ff;
   logic                    last_ff, last_in;
   logic [REPORT_WIDTH-1:0] line_ff, block_ff;
   logic                    load;
   logic                    final_beat;

   // a group is done after its second beat, or after its only one
   assign final_beat = !head_entry.two || sub_ff;
   assign load       = head_valid && (!valid_ff || rsp_ch.ready);
   assign head_pop   = load && final_beat;
   assign byte_in    = (head_entry.two && sub_ff) ? head_entry.byte1 : head_entry.byte0;
   assign last_in    = head_entry.last && final_beat;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 1'b0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            sub_ff   <= !final_beat;
         end else if (rsp_ch.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff  <= byte_in;
         has_ff   <= head_entry.has_byte;
         last_ff  <= last_in;
         line_ff  <= head_entry.line_total;
         block_ff <= head_entry.block_total;
      end
   end

   assign rsp_ch.valid               = valid_ff;
   assign rsp_ch.out_byte            = byte_ff;
   assign rsp_ch.has_byte            = has_ff;
   assign rsp_ch.last_result         = last_ff;
   assign rsp_ch.line_comment_total  = line_ff;
   assign rsp_ch.block_comment_total = block_ff;

endmodule

// ===== rtl/dcs_checker.sv =====
// Port-level checks of the stripper core, bound to the top level.
`timescale 1ns / 1ps

`include "dash_comment_stripper_core_assert.svh"

module dcs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_has_byte,
   input logic        rsp_last_result,
   input logic [15:0] rsp_line_total,
   input logic [15:0] rsp_block_total
);

   `DCS_ASSERT_NEXT(a_rsp_valid_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp valid dropped while stalled")

   `DCS_ASSERT_NEXT(a_rsp_beat_holds, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_out_byte) && $stable(rsp_has_byte) && $stable(rsp_last_result) && $stable(rsp_line_total) && $stable(rsp_block_total), "rsp beat changed while stalled")

   `DCS_ASSERT_IMPLY(a_empty_is_final, clock, reset, rsp_valid && !rsp_has_byte, rsp_last_result && rsp_out_byte == 8'd0, "empty beat that is not the final one")

   `DCS_ASSERT_NEXT_ALWAYS(a_reset_clean, clock, reset, req_ready && !rsp_valid, "not idle after reset")

endmodule

bind dash_comment_stripper_core dcs_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_out_byte    (rsp_ch.out_byte),
   .rsp_has_byte    (rsp_ch.has_byte),
   .rsp_last_result (rsp_ch.last_result),
   .rsp_line_total  (rsp_ch.line_comment_total),
   .rsp_block_total (rsp_ch.block_comment_total)
);
